// ===== rtl/core/cup_fill_dispense_controller_top_defines.svh =====
// ----------------------------------------------------------------------------
// Cup fill dispense controller - assertion macros
// Shared property wrappers, clocked on clock; CFD_ASSERT is held off during reset.
// ----------------------------------------------------------------------------
`ifndef CUP_FILL_DISPENSE_CONTROLLER_TOP_DEFINES_SVH
`define CUP_FILL_DISPENSE_CONTROLLER_TOP_DEFINES_SVH

// checked only outside reset
`define CFD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define CFD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, widths and codes shared by the cup fill dispense controller.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int WEIGHT_BITS = 12;
   localparam int CFG_BITS    = 12;
   localparam int FILL_BITS   = WEIGHT_BITS + 1;
   localparam int VAL_BITS    = (WEIGHT_BITS > CFG_BITS) ? WEIGHT_BITS : CFG_BITS;
   localparam int CMP_BITS    = VAL_BITS + 3;

   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int IDX_BITS    = 2;

   localparam int REQ_DATA_BITS = ((WEIGHT_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_BITS  = STATUS_BITS + 1 + FILL_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;

   localparam logic [MODE_BITS-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TARE   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_START  = 2'd2;

   localparam logic [IDX_BITS-1:0] REG_MAX_FILL  = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_DROP_TOL  = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_CUP_MIN   = 2'd2;
   localparam logic [IDX_BITS-1:0] REG_CUP_MAX   = 2'd3;

   localparam logic [CFG_BITS-1:0] MAX_FILL_RST = 12'd50;
   localparam logic [CFG_BITS-1:0] DROP_TOL_RST = 12'd10;
   localparam logic [CFG_BITS-1:0] CUP_MIN_RST  = 12'd5;
   localparam logic [CFG_BITS-1:0] CUP_MAX_RST  = 12'd500;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_IGNORED   = 3'd0,
      ST_TARED     = 3'd1,
      ST_NOT_EMPTY = 3'd2,
      ST_BUSY      = 3'd3,
      ST_NO_TARE   = 3'd4,
      ST_FILLING   = 3'd5,
      ST_FULL      = 3'd6,
      ST_REMOVED   = 3'd7
   } cfd_status_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] max_fill;
      logic [CFG_BITS-1:0] drop_tolerance;
      logic [CFG_BITS-1:0] cup_min;
      logic [CFG_BITS-1:0] cup_max;
   } cfd_cfg_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]   mode;
      logic [WEIGHT_BITS-1:0] weight;
   } cfd_item_type;

   typedef struct packed {
      cfd_status_type               status;
      logic                         pump_on;
      logic signed [FILL_BITS-1:0]  fill_amount;
   } cfd_result_type;

endpackage

// ===== rtl/core/cfd_csr.sv =====
// ----------------------------------------------------------------------------
// cfd_csr
// Configuration registers: fill limit, drop tolerance and cup weight window.
// ----------------------------------------------------------------------------
module cfd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [cfd_pkg::IDX_BITS-1:0] csr_index,
   input  logic [cfd_pkg::CFG_BITS-1:0] csr_data,
   output cfd_pkg::cfd_cfg_type         cfg
);
   import cfd_pkg::*;

   cfd_cfg_type cfg_ff;
   cfd_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_FILL: cfg_in.max_fill       = csr_data;
            REG_DROP_TOL: cfg_in.drop_tolerance = csr_data;
            REG_CUP_MIN:  cfg_in.cup_min        = csr_data;
            REG_CUP_MAX:  cfg_in.cup_max        = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fill       <= MAX_FILL_RST;
         cfg_ff.drop_tolerance <= DROP_TOL_RST;
         cfg_ff.cup_min        <= CUP_MIN_RST;
         cfg_ff.cup_max        <= CUP_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/cfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// cfd_in_stage
// Input register: holds one accepted word until the evaluator takes it.
// ----------------------------------------------------------------------------
module cfd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cfd_pkg::cfd_item_type in_item,
   output logic                  item_valid,
   input  logic                  item_take,
   output cfd_pkg::cfd_item_type item
);
   import cfd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   cfd_item_type item_ff;
   logic         pop;

   assign pop        = valid_ff && item_take;
   assign in_ready   = !valid_ff || pop;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== rtl/core/cfd_eval.sv =====
// ----------------------------------------------------------------------------
// cfd_eval
// Dispense state (pump, tare, fill) and event evaluation into the result
// register.
// ----------------------------------------------------------------------------
`include "cup_fill_dispense_controller_top_defines.svh"

module cfd_eval (
   input  logic                    clock,
   input  logic                    reset,
   input  cfd_pkg::cfd_cfg_type    cfg,
   input  logic                    item_valid,
   output logic                    item_take,
   input  cfd_pkg::cfd_item_type   item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cfd_pkg::cfd_result_type result
);
   import cfd_pkg::*;

   logic                          pumping_ff;
   logic                          pumping_in;
   logic [WEIGHT_BITS-1:0]        tare_ff;
   logic [WEIGHT_BITS-1:0]        tare_in;
   logic signed [FILL_BITS-1:0]   fill_ff;
   logic signed [FILL_BITS-1:0]   fill_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   cfd_result_type                result_ff;
   cfd_result_type                result_in;

   logic                          load;
   logic signed [FILL_BITS-1:0]   sample_fill;
   logic signed [CMP_BITS-1:0]    prev_x;
   logic signed [CMP_BITS-1:0]    limit_x;
   logic signed [CMP_BITS-1:0]    sample_x;
   logic signed [CMP_BITS-1:0]    max_x;
   logic [VAL_BITS-1:0]           w_v;
   logic [VAL_BITS-1:0]           min_v;
   logic [VAL_BITS-1:0]           max_v;
   logic                          removed;
   logic                          full;
   logic                          cup_bad;

   assign item_take = !out_valid_ff || out_ready;
   assign load      = item_valid && item_take;
   assign out_valid = out_valid_ff;
   assign result    = result_ff;

   assign sample_fill = signed'({1'b0, item.weight}) - signed'({1'b0, tare_ff});
   assign prev_x      = CMP_BITS'(fill_ff);
   assign sample_x    = CMP_BITS'(sample_fill);
   assign limit_x     = sample_x + signed'(CMP_BITS'(cfg.drop_tolerance));
   assign max_x       = signed'(CMP_BITS'(cfg.max_fill));
   assign removed     = prev_x > limit_x;
   assign full        = sample_x >= max_x;

   assign w_v     = VAL_BITS'(item.weight);
   assign min_v   = VAL_BITS'(cfg.cup_min);
   assign max_v   = VAL_BITS'(cfg.cup_max);
   assign cup_bad = (w_v <= min_v) || (w_v > max_v);

   always_comb begin
      pumping_in            = pumping_ff;
      tare_in               = tare_ff;
      fill_in               = fill_ff;
      result_in.status      = ST_IGNORED;
      result_in.fill_amount = fill_ff;
      unique case (item.mode)
         MODE_TARE: begin
            if (pumping_ff) begin
               result_in.status = ST_BUSY;
            end else if (cup_bad) begin
               tare_in          = '0;
               result_in.status = ST_NOT_EMPTY;
            end else begin
               tare_in               = item.weight;
               fill_in               = '0;
               result_in.status      = ST_TARED;
               result_in.fill_amount = '0;
            end
         end
         MODE_START: begin
            result_in.fill_amount = '0;
            if (pumping_ff) begin
               result_in.status      = ST_BUSY;
               result_in.fill_amount = fill_ff;
            end else if (tare_ff == '0) begin
               result_in.status = ST_NO_TARE;
            end else if (cfg.max_fill == '0) begin
               tare_in          = '0;
               fill_in          = '0;
               result_in.status = ST_FULL;
            end else begin
               pumping_in       = 1'b1;
               fill_in          = '0;
               result_in.status = ST_FILLING;
            end
         end
         MODE_SAMPLE: begin
            if (pumping_ff) begin
               result_in.fill_amount = sample_fill;
               if (removed || full) begin
                  pumping_in       = 1'b0;
                  tare_in          = '0;
                  fill_in          = '0;
                  result_in.status = removed ? ST_REMOVED : ST_FULL;
               end else begin
                  fill_in          = sample_fill;
                  result_in.status = ST_FILLING;
               end
            end
         end
         default: begin
            result_in.status = ST_IGNORED;
         end
      endcase
      result_in.pump_on = pumping_in;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pumping_ff   <= 1'b0;
         tare_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (load) begin
            pumping_ff <= pumping_in;
            tare_ff    <= tare_in;
            fill_ff    <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   `CFD_ASSERT(a_pump_needs_tare, pumping_ff |-> (tare_ff != '0), "pumping with no tare")
   `CFD_ASSERT(a_idle_fill_zero, !pumping_ff |-> (fill_ff == '0), "fill kept while idle")
   `CFD_ASSERT(a_full_pump_off, (out_valid_ff && result_ff.status == ST_FULL) |-> !result_ff.pump_on, "pump on after full")
   `CFD_ASSERT(a_start_word, $rose(pumping_ff) |-> (out_valid_ff && result_ff.status == ST_FILLING), "pump started without start word")

endmodule

// ===== rtl/core/cup_fill_dispense_controller_top.sv =====
// ----------------------------------------------------------------------------
// cup_fill_dispense_controller_top
// Scale-driven drink dispenser controller: tare, start and fill monitoring.
// ----------------------------------------------------------------------------
// Each request word (tuser = mode: sample, tare or start; tdata = weight)
// gives exactly one response word carrying status, pump drive and the signed
// fill in grams. One word is taken every clock while responses are taken. A
// word is held in the input register at acceptance; its response is loaded
// into the result register when the evaluator takes the word, which a
// held-off response can delay, and is presented from there. The subtract and
// compares of the evaluator sit between the two registers. A held-off response
// stalls the input once the input register is also full.
// The user must write registers over the csr port only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module cup_fill_dispense_controller_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cfd_pkg::REQ_DATA_BITS-1:0] req_tdata,   // weight
   input  logic [cfd_pkg::MODE_BITS-1:0]     req_tuser,   // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cfd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // status, pump_on, fill_amount
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cfd_pkg::IDX_BITS-1:0]      csr_index,
   input  logic [cfd_pkg::CFG_BITS-1:0]      csr_data
);
   import cfd_pkg::*;

   cfd_cfg_type    cfg;
   cfd_item_type   in_item;
   cfd_item_type   item;
   cfd_result_type result;
   logic           item_valid;
   logic           item_take;

   assign in_item.mode   = req_tuser;
   assign in_item.weight = req_tdata[WEIGHT_BITS-1:0];

   assign rsp_tdata = RSP_DATA_BITS'({result.fill_amount, result.pump_on, result.status});

   cfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   cfd_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .result     (result)
   );

endmodule
